// File: hdl/qsd_pkg.sv
// Shared types, constants and helpers for the QOI stream decoder.
// No dependencies; compiled first.
package qsd_pkg;

    localparam int INDEX_ENTRIES_DEF = 64;
    localparam logic [3:0] HEADER_BYTES = 4'd14;

    localparam int BYTE_W  = 8;
    localparam int PIX_W   = 32;
    localparam int POS_W   = 32;
    localparam int LEN_W   = 6;
    localparam int SCALE_W = 4;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_RUN    = 2'd0;
    localparam t_kind KIND_HDR_OK = 2'd1;
    localparam t_kind KIND_HDR_BAD = 2'd2;

    typedef enum logic [2:0] {
        MODE_HEADER = 3'b001,
        MODE_PIXELS = 3'b010,
        MODE_IDLE   = 3'b100
    } t_mode;

    localparam logic [7:0] OP_RGB  = 8'hFE;
    localparam logic [7:0] OP_RGBA = 8'hFF;

    // Two-bit tag in the top of an op byte
    localparam logic [1:0] TAG_INDEX = 2'b00;
    localparam logic [1:0] TAG_DIFF  = 2'b01;
    localparam logic [1:0] TAG_LUMA  = 2'b10;
    localparam logic [1:0] TAG_RUN   = 2'b11;

    localparam logic [PIX_W-1:0] PREV_RESET = 32'hFF00_0000;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        begin
            case (idx)
                2'd0:    m = 8'h71;
                2'd1:    m = 8'h6F;
                2'd2:    m = 8'h69;
                2'd3:    m = 8'h66;
                default: m = 8'h00;
            endcase
            return m;
        end
    endfunction

    function automatic logic [SCALE_W-1:0] scale_of(input logic [31:0] w,
                                                   input logic [31:0] h);
        logic [SCALE_W-1:0] s;
        begin
            if (w == 32'd240 && h == 32'd135)        s = 4'd8;
            else if (w == 32'd480 && h == 32'd270)   s = 4'd4;
            else if (w == 32'd960 && h == 32'd540)   s = 4'd2;
            else if (w == 32'd1920 && h == 32'd1080) s = 4'd1;
            else                                      s = 4'd0;
            return s;
        end
    endfunction

endpackage

// File: hdl/qsd_in_if.sv
// Byte channel into the decoder: valid/ready plus one file byte and markers.
// Depends on qsd_pkg.
interface qsd_in_if;
    import qsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input last_byte, output ready);
endinterface

// File: hdl/qsd_out_if.sv
// Result channel out of the decoder: valid/ready plus one run or header status.
// Depends on qsd_pkg.
interface qsd_out_if;
    import qsd_pkg::*;

    logic               valid;
    logic               ready;
    t_kind              result_kind;
    logic [PIX_W-1:0]   pixel_argb;
    logic [POS_W-1:0]   run_start;
    logic [LEN_W-1:0]   run_length;
    logic [SCALE_W-1:0] scale_factor;
    logic               image_done;

    modport source (output valid, output result_kind, output pixel_argb,
                    output run_start, output run_length, output scale_factor,
                    output image_done, input ready);
    modport sink   (input valid, input result_kind, input pixel_argb,
                    input run_start, input run_length, input scale_factor,
                    input image_done, output ready);
endinterface

// File: hdl/qoi_stream_decoder_top.sv
// Channel   Dir  Payload                                           Transfer
// i_byte_ch in   data_byte[7:0], first_byte, last_byte              valid & ready
// o_run_ch  out  result_kind, pixel_argb, run_start, run_length,    valid & ready
//                scale_factor, image_done
// One byte per cycle sustained while the output is not stalled.
// Each byte's work is one combinational pass between the input and result registers;
// the 64-entry colour index is read at transfer, with a bypass for the write in flight.
// Reset (synchronous, active low) and first_byte clear the index valid bits at once,
// so no clearing pass is needed. A stalled result holds the input and result registers.
// Depends on qsd_pkg, qsd_in_if, qsd_out_if.
module qoi_stream_decoder_top #(
    parameter int INDEX_ENTRIES = qsd_pkg::INDEX_ENTRIES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qsd_in_if.sink   i_byte_ch,
    qsd_out_if.source o_run_ch
);
    import qsd_pkg::*;

    localparam int IDX_W = $clog2(INDEX_ENTRIES);

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;
    logic              r_in_last;

    // decoder state
    logic [3:0]        r_hdr_cnt,  c_hdr_cnt,  n_hdr_cnt;
    logic [31:0]       r_width,    c_width,    n_width;
    logic [31:0]       r_height,   c_height,   n_height;
    logic [POS_W-1:0]  r_total,    c_total,    n_total;
    logic [POS_W-1:0]  r_pos,      c_pos,      n_pos;
    logic [PIX_W-1:0]  r_prev,     c_prev,     n_prev;
    logic [7:0]        r_op,       c_op,       n_op;
    logic [2:0]        r_opcnt,    c_opcnt,    n_opcnt;
    logic [31:0]       r_opbytes,  c_opbytes,  n_opbytes;
    t_mode             r_mode,     c_mode,     n_mode;
    logic [INDEX_ENTRIES-1:0] r_vld, n_vld;

    // colour index memory
    logic [PIX_W-1:0]  r_idx_mem [INDEX_ENTRIES];
    logic [PIX_W-1:0]  r_rd_data;
    logic              r_byp;
    logic [PIX_W-1:0]  r_byp_data;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  rd_addr;
    logic [PIX_W-1:0]  idx_px;

    // result register
    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [PIX_W-1:0]   r_out_px;
    logic [POS_W-1:0]   r_out_start;
    logic [LEN_W-1:0]   r_out_len;
    logic [SCALE_W-1:0] r_out_scale;
    logic               r_out_done;

    logic               res_valid;
    t_kind              res_kind;
    logic [PIX_W-1:0]   res_px;
    logic [POS_W-1:0]   res_start;
    logic [LEN_W-1:0]   res_len;
    logic [SCALE_W-1:0] res_scale;
    logic               res_done;

    logic              in_fire;
    logic              proc_fire;

    // pass-local values
    logic [7:0]        pa, pr, pg, pb;
    logic [7:0]        na, nr, ng, nb;
    logic [7:0]        vg;
    logic [6:0]        run_len;
    logic [POS_W-1:0]  remaining;
    logic [6:0]        len_full;
    logic              pos_done;
    logic              store_px;
    logic [11:0]       h_sum;

    assign proc_fire = r_in_valid && (!r_out_valid || o_run_ch.ready);
    assign i_byte_ch.ready = !r_in_valid || proc_fire;
    assign in_fire = i_byte_ch.valid && i_byte_ch.ready;
    assign rd_addr = i_byte_ch.data_byte[IDX_W-1:0];

    // INDEX op entry: registered read, patched by a same-edge write, zero if not valid
    always_comb begin
        if (r_vld[r_in_byte[IDX_W-1:0]]) begin
            idx_px = r_byp ? r_byp_data : r_rd_data;
        end else begin
            idx_px = '0;
        end
    end

    always_comb begin
        // first_byte restarts from the reset state before the byte is used
        c_hdr_cnt = r_in_first ? 4'd0        : r_hdr_cnt;
        c_width   = r_in_first ? 32'd0       : r_width;
        c_height  = r_in_first ? 32'd0       : r_height;
        c_total   = r_in_first ? '0          : r_total;
        c_pos     = r_in_first ? '0          : r_pos;
        c_prev    = r_in_first ? PREV_RESET  : r_prev;
        c_op      = r_in_first ? 8'd0        : r_op;
        c_opcnt   = r_in_first ? 3'd0        : r_opcnt;
        c_opbytes = r_in_first ? 32'd0       : r_opbytes;
        c_mode    = r_in_first ? MODE_HEADER : r_mode;
        n_vld     = r_in_first ? '0          : r_vld;

        n_hdr_cnt = c_hdr_cnt;
        n_width   = c_width;
        n_height  = c_height;
        n_total   = c_total;
        n_pos     = c_pos;
        n_prev    = c_prev;
        n_op      = c_op;
        n_opcnt   = c_opcnt;
        n_opbytes = c_opbytes;
        n_mode    = c_mode;

        res_valid = 1'b0;
        res_kind  = KIND_RUN;
        res_px    = '0;
        res_start = '0;
        res_len   = '0;
        res_scale = '0;
        res_done  = 1'b0;

        pa = c_prev[31:24];
        pr = c_prev[23:16];
        pg = c_prev[15:8];
        pb = c_prev[7:0];
        na = pa;
        nr = pr;
        ng = pg;
        nb = pb;
        vg = 8'd0;
        run_len   = 7'd1;
        store_px  = 1'b0;
        remaining = '0;
        len_full  = '0;
        pos_done  = 1'b0;
        h_sum     = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;

        case (c_mode)
            MODE_HEADER: begin
                if (c_hdr_cnt[3:2] == 2'b00 &&
                    r_in_byte != magic_byte(c_hdr_cnt[1:0])) begin
                    n_mode    = MODE_IDLE;
                    res_valid = 1'b1;
                    res_kind  = KIND_HDR_BAD;
                end else begin
                    if (c_hdr_cnt[3:2] == 2'b01) begin
                        n_width = {c_width[23:0], r_in_byte};
                    end else if (c_hdr_cnt[3:2] == 2'b10) begin
                        n_height = {c_height[23:0], r_in_byte};
                    end
                    n_hdr_cnt = c_hdr_cnt + 4'd1;
                    if (n_hdr_cnt == HEADER_BYTES) begin
                        res_valid = 1'b1;
                        if (c_width == 32'd0 || c_height == 32'd0) begin
                            n_mode   = MODE_IDLE;
                            res_kind = KIND_HDR_BAD;
                        end else begin
                            // bytes 12 and 13 leave width and height alone
                            n_total   = c_width * c_height;
                            n_mode    = (n_total == '0 || r_in_last) ? MODE_IDLE
                                                                      : MODE_PIXELS;
                            res_kind  = KIND_HDR_OK;
                            res_scale = scale_of(c_width, c_height);
                            res_done  = (n_total == '0);
                        end
                    end else if (r_in_last) begin
                        n_mode    = MODE_IDLE;
                        res_valid = 1'b1;
                        res_kind  = KIND_HDR_BAD;
                    end
                end
            end

            MODE_PIXELS: begin
                if (c_opcnt == 3'd0) begin
                    n_op      = r_in_byte;
                    n_opbytes = 32'd0;
                    if (r_in_byte == OP_RGB) begin
                        n_opcnt = 3'd3;
                    end else if (r_in_byte == OP_RGBA) begin
                        n_opcnt = 3'd4;
                    end else if (r_in_byte[7:6] == TAG_LUMA) begin
                        n_opcnt = 3'd1;
                    end
                end else begin
                    n_opbytes = {c_opbytes[23:0], r_in_byte};
                    n_opcnt   = c_opcnt - 3'd1;
                end

                if (n_opcnt != 3'd0) begin
                    // op still waits for operands; dropped if the file ends here
                    if (r_in_last) begin
                        n_opcnt = 3'd0;
                        n_mode  = MODE_IDLE;
                    end
                end else begin
                    if (n_op == OP_RGB) begin
                        nr = n_opbytes[23:16];
                        ng = n_opbytes[15:8];
                        nb = n_opbytes[7:0];
                        store_px = 1'b1;
                    end else if (n_op == OP_RGBA) begin
                        na = n_opbytes[7:0];
                        nr = n_opbytes[31:24];
                        ng = n_opbytes[23:16];
                        nb = n_opbytes[15:8];
                        store_px = 1'b1;
                    end else begin
                        case (n_op[7:6])
                            TAG_INDEX: begin
                                na = idx_px[31:24];
                                nr = idx_px[23:16];
                                ng = idx_px[15:8];
                                nb = idx_px[7:0];
                            end
                            TAG_DIFF: begin
                                nr = pr + {6'd0, n_op[5:4]} - 8'd2;
                                ng = pg + {6'd0, n_op[3:2]} - 8'd2;
                                nb = pb + {6'd0, n_op[1:0]} - 8'd2;
                                store_px = 1'b1;
                            end
                            TAG_LUMA: begin
                                vg = {2'd0, n_op[5:0]} - 8'd32;
                                nr = pr + vg - 8'd8 + {4'd0, n_opbytes[7:4]};
                                ng = pg + vg;
                                nb = pb + vg - 8'd8 + {4'd0, n_opbytes[3:0]};
                                store_px = 1'b1;
                            end
                            TAG_RUN: begin
                                run_len = {1'b0, n_op[5:0]} + 7'd1;
                            end
                            default: begin
                                run_len = 7'd1;
                            end
                        endcase
                    end
                    n_prev = {na, nr, ng, nb};

                    h_sum = {4'd0, nr} * 12'd3 + {4'd0, ng} * 12'd5 +
                            {4'd0, nb} * 12'd7 + {4'd0, na} * 12'd11;
                    mem_we    = store_px;
                    mem_waddr = h_sum[IDX_W-1:0];
                    if (store_px) begin
                        n_vld[mem_waddr] = 1'b1;
                    end

                    // clip the run at the end of the image
                    remaining = c_total - c_pos;
                    if (remaining > {{(POS_W-7){1'b0}}, run_len}) begin
                        len_full = run_len;
                    end else begin
                        len_full = remaining[6:0];
                    end
                    n_pos    = c_pos + {{(POS_W-7){1'b0}}, len_full};
                    pos_done = (n_pos == c_total);
                    if (pos_done || r_in_last) begin
                        n_mode = MODE_IDLE;
                    end

                    res_valid = 1'b1;
                    res_kind  = KIND_RUN;
                    res_px    = n_prev;
                    res_start = c_pos;
                    res_len   = len_full[LEN_W-1:0];
                    res_scale = scale_of(c_width, c_height);
                    res_done  = pos_done;
                end
            end

            default: begin
                n_mode = c_mode;
            end
        endcase
    end

    // index memory: one write port, one registered read at transfer
    always_ff @(posedge i_clk) begin
        if (proc_fire && mem_we) begin
            r_idx_mem[mem_waddr] <= n_prev;
        end
        if (in_fire) begin
            r_rd_data  <= r_idx_mem[rd_addr];
            r_byp_data <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (in_fire) begin
            r_byp <= proc_fire && mem_we && (mem_waddr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte  <= i_byte_ch.data_byte;
            r_in_first <= i_byte_ch.first_byte;
            r_in_last  <= i_byte_ch.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt <= 4'd0;
            r_width   <= 32'd0;
            r_height  <= 32'd0;
            r_total   <= '0;
            r_pos     <= '0;
            r_prev    <= PREV_RESET;
            r_op      <= 8'd0;
            r_opcnt   <= 3'd0;
            r_opbytes <= 32'd0;
            r_mode    <= MODE_HEADER;
            r_vld     <= '0;
        end else if (proc_fire) begin
            r_hdr_cnt <= n_hdr_cnt;
            r_width   <= n_width;
            r_height  <= n_height;
            r_total   <= n_total;
            r_pos     <= n_pos;
            r_prev    <= n_prev;
            r_op      <= n_op;
            r_opcnt   <= n_opcnt;
            r_opbytes <= n_opbytes;
            r_mode    <= n_mode;
            r_vld     <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= res_valid;
        end else if (o_run_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && res_valid) begin
            r_out_kind  <= res_kind;
            r_out_px    <= res_px;
            r_out_start <= res_start;
            r_out_len   <= res_len;
            r_out_scale <= res_scale;
            r_out_done  <= res_done;
        end
    end

    assign o_run_ch.valid        = r_out_valid;
    assign o_run_ch.result_kind  = r_out_kind;
    assign o_run_ch.pixel_argb   = r_out_px;
    assign o_run_ch.run_start    = r_out_start;
    assign o_run_ch.run_length   = r_out_len;
    assign o_run_ch.scale_factor = r_out_scale;
    assign o_run_ch.image_done   = r_out_done;

endmodule
